[hw/rtl/source_text_canonicalizer_assert.svh]
// ----------------------------------------------------------------------------
// Source text canonicalizer assertion macros
// Shared concurrent assertion forms used by the canonicalizer RTL.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_CANONICALIZER_ASSERT_SVH
`define SOURCE_TEXT_CANONICALIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define STC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define STC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// Source text canonicalizer package
// Types, character constants and defaults shared by the canonicalizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_COMMENT = 4'b0010,
        MODE_QUOTE   = 4'b0100,
        MODE_ESCAPE  = 4'b1000
    } scan_mode_t;

    // Work for the back end: up to three bytes in the order slash, space, byte.
    typedef struct packed {
        logic       flush_slash;
        logic       add_space;
        logic       put_byte;
        logic [7:0] data;
        logic       text_last;
    } plan_t;

    typedef struct packed {
        scan_mode_t mode;
        logic       slash_pending;
    } front_status_t;

endpackage

`default_nettype wire

[hw/rtl/stc_front.sv]
// ----------------------------------------------------------------------------
// Canonicalizer front end
// Accepts text bytes, tracks the scanner state and queues the output plan.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_last,
    input  wire logic                  q_full,
    output logic                       push,
    output stc_pkg::plan_t             push_plan,
    output stc_pkg::front_status_t     status
);
    import stc_pkg::*;

    scan_mode_t mode_reg, mode_next;
    logic       quote_dq_reg, quote_dq_next;
    logic       slash_pending_reg, slash_pending_next;
    logic       space_seen_reg, space_seen_next;
    logic       prev_word_reg, prev_word_next;
    logic       accept;
    logic       pass;
    logic       is_slash;
    logic       is_quote;
    logic       byte_word;
    logic       byte_space;
    plan_t      plan;

    function automatic logic is_word(input logic [7:0] c);
        is_word = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                  (c >= 8'h61 && c <= 8'h7A) || (c == CHAR_UNDERSCORE);
    endfunction

    assign is_slash   = (in_byte == CHAR_SLASH);
    assign is_quote   = (in_byte == CHAR_DQUOTE) || (in_byte == CHAR_SQUOTE);
    assign byte_word  = is_word(in_byte);
    assign byte_space = (in_byte == CHAR_SPACE) || (in_byte >= 8'h09 && in_byte <= 8'h0D);

    always_comb begin
        plan               = '0;
        plan.data          = in_byte;
        plan.text_last     = in_last;
        pass               = 1'b1;
        mode_next          = mode_reg;
        quote_dq_next      = quote_dq_reg;
        slash_pending_next = slash_pending_reg;
        space_seen_next    = space_seen_reg;
        prev_word_next     = prev_word_reg;
        case (mode_reg)
            MODE_NORMAL: begin
                if (slash_pending_reg) begin
                    slash_pending_next = 1'b0;
                    if (is_slash) begin
                        mode_next       = MODE_COMMENT;
                        space_seen_next = 1'b1;
                        pass            = 1'b0;
                    end else begin
                        plan.flush_slash = 1'b1;
                        space_seen_next  = 1'b0;
                        prev_word_next   = 1'b0;
                    end
                end
                if (pass) begin
                    if (is_slash) begin
                        if (in_last) begin
                            plan.put_byte   = 1'b1;
                            space_seen_next = 1'b0;
                            prev_word_next  = 1'b0;
                        end else begin
                            slash_pending_next = 1'b1;
                        end
                    end else if (byte_space) begin
                        space_seen_next = 1'b1;
                    end else if (is_quote) begin
                        plan.add_space  = space_seen_next && prev_word_next;
                        plan.put_byte   = 1'b1;
                        space_seen_next = 1'b0;
                        prev_word_next  = 1'b0;
                        quote_dq_next   = (in_byte == CHAR_DQUOTE);
                        mode_next       = MODE_QUOTE;
                    end else begin
                        plan.add_space  = space_seen_next && prev_word_next && byte_word;
                        plan.put_byte   = 1'b1;
                        space_seen_next = 1'b0;
                        prev_word_next  = byte_word;
                    end
                end
            end
            MODE_COMMENT: begin
                if (in_byte == CHAR_NEWLINE) begin
                    mode_next       = MODE_NORMAL;
                    space_seen_next = 1'b1;
                end
            end
            MODE_QUOTE: begin
                plan.put_byte = 1'b1;
                if (in_byte == CHAR_BACKSLASH && !in_last) begin
                    mode_next = MODE_ESCAPE;
                end else if (in_byte == (quote_dq_reg ? CHAR_DQUOTE : CHAR_SQUOTE)) begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_ESCAPE: begin
                plan.put_byte = 1'b1;
                mode_next     = MODE_QUOTE;
            end
            default: begin
                mode_next = MODE_NORMAL;
            end
        endcase
        if (in_last) begin
            mode_next          = MODE_NORMAL;
            quote_dq_next      = 1'b0;
            slash_pending_next = 1'b0;
            space_seen_next    = 1'b0;
            prev_word_next     = 1'b0;
        end
    end

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign push      = accept &&
                       (plan.flush_slash || plan.add_space || plan.put_byte || in_last);
    assign push_plan = plan;

    assign status.mode          = mode_reg;
    assign status.slash_pending = slash_pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_NORMAL;
            quote_dq_reg      <= 1'b0;
            slash_pending_reg <= 1'b0;
            space_seen_reg    <= 1'b0;
            prev_word_reg     <= 1'b0;
        end else if (accept) begin
            mode_reg          <= mode_next;
            quote_dq_reg      <= quote_dq_next;
            slash_pending_reg <= slash_pending_next;
            space_seen_reg    <= space_seen_next;
            prev_word_reg     <= prev_word_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stc_queue.sv]
// ----------------------------------------------------------------------------
// Canonicalizer plan queue
// Short first-in first-out queue of output plans between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_queue #(
    parameter int DEPTH = stc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire stc_pkg::plan_t push_plan,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output stc_pkg::plan_t      head
);
    import stc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

    plan_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_plan;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stc_back.sv]
// ----------------------------------------------------------------------------
// Canonicalizer back end
// Expands queued plans into output transactions, one byte per cycle unless out_ready holds the output back.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire stc_pkg::plan_t head,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                out_byte_valid,
    output logic                out_run_last,
    output logic                out_text_end
);
    import stc_pkg::*;

    logic [2:0] done_reg, done_next;
    logic [2:0] wanted;
    logic [2:0] remain;
    logic [2:0] sel;
    logic       is_final;
    logic       marker;
    logic       load;
    logic [7:0] sel_byte;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       byte_valid_reg;
    logic       run_last_reg;
    logic       text_end_reg;

    assign wanted   = {head.put_byte, head.add_space, head.flush_slash};
    assign remain   = wanted & ~done_reg;
    assign sel      = remain & (~remain + 3'd1);
    assign marker   = (remain == 3'd0);
    assign is_final = ((remain & ~sel) == 3'd0);
    assign sel_byte = sel[0] ? CHAR_SLASH : (sel[1] ? CHAR_SPACE : head.data);

    assign load = q_valid && (!valid_reg || out_ready);
    assign pop  = load && is_final;

    always_comb begin
        done_next = done_reg;
        if (load) begin
            done_next = is_final ? 3'd0 : (done_reg | sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= 3'd0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg       <= marker ? 8'd0 : sel_byte;
            byte_valid_reg <= !marker;
            run_last_reg   <= is_final;
            text_end_reg   <= is_final && head.text_last;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign out_byte_valid = byte_valid_reg;
    assign out_run_last   = run_last_reg;
    assign out_text_end   = text_end_reg;

endmodule

`default_nettype wire

[hw/rtl/source_text_canonicalizer.sv]
// The first result of a byte passes through the plan queue and then the back end output
// register before it is presented on the m_ side; older plans and m_ stalls can delay it.
// Throughput: one input byte per cycle while the plan queue has room; the back end
// sends one output transaction per cycle unless m_tready holds it back.
// Sustained rate is set by the output side for dense text.
// Reset: aresetn low synchronously clears the scanner state, the queue and the output.
// ----------------------------------------------------------------------------
// Source text canonicalizer
// Strips line comments, collapses whitespace and copies quoted literals.
// ----------------------------------------------------------------------------
`default_nettype none
`include "source_text_canonicalizer_assert.svh"

module source_text_canonicalizer #(
    parameter int QUEUE_DEPTH = stc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // text_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] text_end, [15:9] zero
    output logic             m_tuser,   // [0] byte_valid
    output logic             m_tlast    // run_last
);
    import stc_pkg::*;

    logic          push;
    plan_t         push_plan;
    logic          q_full;
    logic          q_valid;
    logic          pop;
    plan_t         head;
    front_status_t front_status;
    logic [7:0]    out_byte;
    logic          out_text_end;

    stc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_plan (push_plan),
        .status    (front_status)
    );

    stc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_plan (push_plan),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    stc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (out_byte),
        .out_byte_valid (m_tuser),
        .out_run_last   (m_tlast),
        .out_text_end   (out_text_end)
    );

    assign m_tdata = {7'd0, out_text_end, out_byte};

    `STC_ASSERT_IMPLY(a_marker_ends_text, aclk, aresetn, m_tvalid && !m_tuser,
        m_tlast && m_tdata[8], "End marker must close both the run and the text.")

    `STC_ASSERT_IMPLY(a_text_end_is_run_last, aclk, aresetn, m_tvalid && m_tdata[8],
        m_tlast, "Text end must fall on the last result of its byte.")

    `STC_ASSERT_NEXT(a_last_clears_state, aclk, aresetn, s_tvalid && s_tready && s_tlast,
        front_status.mode == MODE_NORMAL && !front_status.slash_pending,
        "Scanner state must return to normal text after the final byte.")

endmodule

`default_nettype wire

[bench/stc_canon_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Source text canonicalizer checker
// Watches both stream channels of the canonicalizer. Every accepted input
// byte is run through a local copy of the scanner, which queues the output
// transactions that byte must cause. Every accepted output transaction is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------

module stc_canon_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);

    import stc_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_end;
    } canon_out_t;

    canon_out_t  expected_canon_q[$];
    canon_out_t  step_out[3];
    int          step_count;
    int          err_count;
    int          seen_count;

    scan_mode_t  scan_st;
    logic        dquote_open;
    logic        slash_held;
    logic        gap_seen;
    logic        last_was_word;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
        err_count     = 0;
        seen_count    = 0;
    end

    function automatic bit is_word_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == CHAR_UNDERSCORE;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CHAR_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void clear_scanner();
        scan_st       = MODE_NORMAL;
        dquote_open   = 1'b0;
        slash_held    = 1'b0;
        gap_seen      = 1'b0;
        last_was_word = 1'b0;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        if (step_count < 3) begin
            step_out[step_count] = '{out_byte: b, byte_valid: 1'b1,
                                     run_last: 1'b0, text_end: 1'b0};
            step_count++;
        end
    endfunction

    // A separating space goes out only between two word characters.
    function automatic void emit_plain(logic [7:0] b);
        if (gap_seen && last_was_word && is_word_char(b))
            emit_byte(CHAR_SPACE);
        gap_seen = 1'b0;
        emit_byte(b);
        last_was_word = is_word_char(b);
    endfunction

    function automatic void canon_predict_byte(logic [7:0] b, logic last);
        bit consumed;
        logic [7:0] closer;
        consumed   = 1'b0;
        step_count = 0;
        case (scan_st)
            MODE_NORMAL: begin
                if (slash_held) begin
                    slash_held = 1'b0;
                    if (b == CHAR_SLASH) begin
                        scan_st  = MODE_COMMENT;
                        gap_seen = 1'b1;
                        consumed = 1'b1;
                    end else begin
                        emit_plain(CHAR_SLASH);
                    end
                end
                if (!consumed) begin
                    if (b == CHAR_SLASH) begin
                        if (last)
                            emit_plain(b);
                        else
                            slash_held = 1'b1;
                    end else if (is_blank(b)) begin
                        gap_seen = 1'b1;
                    end else if (b == CHAR_DQUOTE || b == CHAR_SQUOTE) begin
                        if (gap_seen && last_was_word)
                            emit_byte(CHAR_SPACE);
                        gap_seen      = 1'b0;
                        emit_byte(b);
                        last_was_word = 1'b0;
                        dquote_open   = (b == CHAR_DQUOTE);
                        scan_st       = MODE_QUOTE;
                    end else begin
                        emit_plain(b);
                    end
                end
            end
            MODE_COMMENT: begin
                if (b == CHAR_NEWLINE) begin
                    scan_st  = MODE_NORMAL;
                    gap_seen = 1'b1;
                end
            end
            MODE_QUOTE: begin
                closer = dquote_open ? CHAR_DQUOTE : CHAR_SQUOTE;
                emit_byte(b);
                if (b == CHAR_BACKSLASH && !last)
                    scan_st = MODE_ESCAPE;
                else if (b == closer)
                    scan_st = MODE_NORMAL;
            end
            default: begin
                emit_byte(b);
                scan_st = MODE_QUOTE;
            end
        endcase

        if (last) begin
            if (step_count == 0) begin
                step_out[0] = '0;
                step_count  = 1;
            end
            step_out[step_count - 1].text_end = 1'b1;
            clear_scanner();
        end
        if (step_count > 0)
            step_out[step_count - 1].run_last = 1'b1;
        for (int i = 0; i < step_count; i++)
            expected_canon_q.push_back(step_out[i]);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        canon_out_t want;
        if (!aresetn) begin
            expected_canon_q.delete();
            clear_scanner();
        end else begin
            if (s_tvalid && s_tready)
                canon_predict_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                seen_count++;
                if (expected_canon_q.size() == 0) begin
                    $error("Unexpected output transaction: byte 0x%0h, byte_valid %0b",
                           m_tdata[7:0], m_tuser);
                    err_count++;
                end else begin
                    want = expected_canon_q.pop_front();
                    check_field("out_byte", want.out_byte, m_tdata[7:0]);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(m_tuser));
                    check_field("run_last", 8'(want.run_last), 8'(m_tlast));
                    check_field("text_end", 8'(want.text_end), 8'(m_tdata[8]));
                    check_field("tdata padding", 8'h00, {1'b0, m_tdata[15:9]});
                end
            end
        end
        fail_count    <= err_count;
        pending_count <= expected_canon_q.size();
        checked_count <= seen_count;
    end

endmodule

[bench/tb_source_text_canonicalizer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Source text canonicalizer testbench
// Feeds short source texts, first hand-written ones for the corner cases and
// then random token streams of words, blanks, comments, literals and noise,
// with random stalls on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_source_text_canonicalizer;

    import stc_pkg::*;

    localparam int TARGET_BYTES = 430;
    localparam int CALM_FROM    = 370;
    localparam int CYCLE_LIMIT  = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int          fail_count;
    int          pending_count;
    int          checked_count;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          texts_sent  = 0;
    bit          s_calm      = 1'b0;
    bit          m_calm      = 1'b0;
    int          m_stall_left = 0;
    logic [7:0]  text_buf[$];

    source_text_canonicalizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stc_canon_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_source_text_canonicalizer NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (m_stall_left > 0) begin
            m_stall_left <= m_stall_left - 1;
            m_tready     <= 1'b0;
        end else if (!m_calm && $urandom_range(0, 5) == 0) begin
            m_stall_left <= $urandom_range(0, 5);
            m_tready     <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_word_char();
        int n;
        n = $urandom_range(0, 62);
        if (n < 10)
            return 8'("0" + n);
        else if (n < 36)
            return 8'("A" + (n - 10));
        else if (n < 62)
            return 8'("a" + (n - 36));
        return CHAR_UNDERSCORE;
    endfunction

    function automatic logic [7:0] rand_blank();
        return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : CHAR_SPACE;
    endfunction

    function automatic logic [7:0] rand_non_newline();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CHAR_NEWLINE) ? CHAR_UNDERSCORE : c;
    endfunction

    task automatic add_token();
        int         n;
        logic [7:0] q;
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                n = $urandom_range(1, 4);
                repeat (n) text_buf.push_back(rand_word_char());
            end
            3, 4: begin
                n = $urandom_range(1, 3);
                repeat (n) text_buf.push_back(rand_blank());
            end
            5: begin
                text_buf.push_back(CHAR_SLASH);
                text_buf.push_back(CHAR_SLASH);
                n = $urandom_range(0, 4);
                repeat (n) text_buf.push_back(rand_non_newline());
                if ($urandom_range(0, 5) != 0)
                    text_buf.push_back(CHAR_NEWLINE);
            end
            6, 7: begin
                q = $urandom_range(0, 1) ? CHAR_DQUOTE : CHAR_SQUOTE;
                text_buf.push_back(q);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        text_buf.push_back(CHAR_BACKSLASH);
                        text_buf.push_back($urandom_range(0, 1) ? q : 8'($urandom_range(0, 255)));
                    end else begin
                        text_buf.push_back($urandom_range(0, 1) ? rand_word_char()
                                                                : 8'($urandom_range(0, 255)));
                    end
                end
                if ($urandom_range(0, 7) != 0)
                    text_buf.push_back(q);
            end
            8: begin
                text_buf.push_back(CHAR_SLASH);
                if ($urandom_range(0, 1))
                    text_buf.push_back(rand_word_char());
            end
            9: push_str($urandom_range(0, 1) ? "+=" : "(;)");
            10: text_buf.push_back(8'($urandom_range(0, 255)));
            default: text_buf.push_back(CHAR_NEWLINE);
        endcase
    endtask

    task automatic n_tokens_fill();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) add_token();
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            if (!s_calm && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_buf[i];
            s_tlast  <= (i == text_buf.size() - 1);
            do @(posedge aclk); while (!s_tready);
            bytes_sent++;
        end
        texts_sent++;
        text_buf.delete();
    endtask

    initial begin
        int wait_cycles;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Word gap through blanks and a comment, then a held slash before a word.
        push_str("a\t_ //c\n9/z");
        send_text();
        // Literal with an escaped quote, a foreign quote inside, then a high byte.
        push_str("w '\\'\"'");
        text_buf.push_back(8'hFF);
        send_text();
        // A slash as the final byte.
        push_str("/");
        send_text();
        // A backslash as the final byte of a literal.
        push_str("\"\\");
        send_text();
        // Text that ends inside a comment gives only an end marker.
        push_str("//");
        text_buf.push_back(8'h00);
        send_text();

        while (bytes_sent < TARGET_BYTES) begin
            if (bytes_sent >= CALM_FROM) begin
                s_calm = 1'b1;
                m_calm = 1'b1;
            end else begin
                s_calm = ($urandom_range(0, 3) == 0);
                m_calm = ($urandom_range(0, 3) == 0);
            end
            n_tokens_fill();
            send_text();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        wait_cycles = 20;
        repeat (wait_cycles) @(posedge aclk);

        $display("Sent %0d text bytes in %0d texts, hand-written corner cases first,",
                 bytes_sent, texts_sent);
        $display("then random token streams; %0d output transactions were checked.",
                 checked_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_source_text_canonicalizer OK");
        end else begin
            $display("tb_source_text_canonicalizer NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/stc_pkg.sv
hw/rtl/stc_front.sv
hw/rtl/stc_queue.sv
hw/rtl/stc_back.sv
hw/rtl/source_text_canonicalizer.sv
bench/stc_canon_checker.sv
bench/tb_source_text_canonicalizer.sv
